### rtl/core/ssht_pkg.sv
`timescale 1ns / 1ps

package ssht_pkg;

	localparam int COORD_WIDTH_DEFAULT = 24;
	localparam int RADIUS_WIDTH        = 23;
	localparam int R2_WIDTH            = 2 * RADIUS_WIDTH;

	localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = RADIUS_WIDTH'(2560);
	localparam logic [R2_WIDTH-1:0]     R2_RESET     = R2_WIDTH'(2560 * 2560);

	typedef struct packed {
		logic hit;
		logic crossing;
		logic near;
	} result_t;

endpackage

### rtl/core/ssht_diff.sv
`timescale 1ns / 1ps

module ssht_diff import ssht_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] sx,
	input  logic signed [CW-1:0] sy,
	input  logic signed [CW-1:0] ex,
	input  logic signed [CW-1:0] ey,
	input  logic signed [CW-1:0] px,
	input  logic signed [CW-1:0] py,
	input  logic signed [CW-1:0] qx,
	input  logic signed [CW-1:0] qy,
	output logic signed [CW:0]   ux_s1,
	output logic signed [CW:0]   uy_s1,
	output logic signed [CW:0]   vx_s1,
	output logic signed [CW:0]   vy_s1,
	output logic signed [CW:0]   wx_s1,
	output logic signed [CW:0]   wy_s1,
	output logic signed [CW:0]   dpx_s1,
	output logic signed [CW:0]   dpy_s1,
	output logic signed [CW:0]   dqx_s1,
	output logic signed [CW:0]   dqy_s1
);

	localparam int DW = CW + 1;

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1  <= DW'(ex) - DW'(sx);
			uy_s1  <= DW'(ey) - DW'(sy);
			vx_s1  <= DW'(qx) - DW'(px);
			vy_s1  <= DW'(qy) - DW'(py);
			wx_s1  <= DW'(px) - DW'(sx);
			wy_s1  <= DW'(py) - DW'(sy);
			dpx_s1 <= DW'(px) - DW'(ex);
			dpy_s1 <= DW'(py) - DW'(ey);
			dqx_s1 <= DW'(qx) - DW'(ex);
			dqy_s1 <= DW'(qy) - DW'(ey);
		end
	end

endmodule

### rtl/core/ssht_mult.sv
`timescale 1ns / 1ps

module ssht_mult import ssht_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [CW:0]     ux,
	input  logic signed [CW:0]     uy,
	input  logic signed [CW:0]     vx,
	input  logic signed [CW:0]     vy,
	input  logic signed [CW:0]     wx,
	input  logic signed [CW:0]     wy,
	input  logic signed [CW:0]     dpx,
	input  logic signed [CW:0]     dpy,
	input  logic signed [CW:0]     dqx,
	input  logic signed [CW:0]     dqy,
	output logic signed [2*CW+2:0] den_s3,
	output logic signed [2*CW+2:0] nt_s3,
	output logic signed [2*CW+2:0] nr_s3,
	output logic signed [2*CW+2:0] dp_s3,
	output logic signed [2*CW+2:0] dq_s3
);

	localparam int PW = 2 * CW + 2;
	localparam int XW = 2 * CW + 3;

	logic signed [PW-1:0] uxvy_s2, uyvx_s2, wxvy_s2, wyvx_s2, wxuy_s2, wyux_s2;
	logic signed [PW-1:0] dpx2_s2, dpy2_s2, dqx2_s2, dqy2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			uxvy_s2 <= PW'(ux) * PW'(vy);
			uyvx_s2 <= PW'(uy) * PW'(vx);
			wxvy_s2 <= PW'(wx) * PW'(vy);
			wyvx_s2 <= PW'(wy) * PW'(vx);
			wxuy_s2 <= PW'(wx) * PW'(uy);
			wyux_s2 <= PW'(wy) * PW'(ux);
			dpx2_s2 <= PW'(dpx) * PW'(dpx);
			dpy2_s2 <= PW'(dpy) * PW'(dpy);
			dqx2_s2 <= PW'(dqx) * PW'(dqx);
			dqy2_s2 <= PW'(dqy) * PW'(dqy);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= XW'(uxvy_s2) - XW'(uyvx_s2);
			nt_s3  <= XW'(wxvy_s2) - XW'(wyvx_s2);
			nr_s3  <= XW'(wxuy_s2) - XW'(wyux_s2);
			dp_s3  <= XW'(dpx2_s2) + XW'(dpy2_s2);
			dq_s3  <= XW'(dqx2_s2) + XW'(dqy2_s2);
		end
	end

endmodule

### rtl/core/ssht_decide.sv
`timescale 1ns / 1ps

module ssht_decide import ssht_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEFAULT
) (
	input  logic signed [2*CW+2:0] den,
	input  logic signed [2*CW+2:0] nt,
	input  logic signed [2*CW+2:0] nr,
	input  logic signed [2*CW+2:0] dp,
	input  logic signed [2*CW+2:0] dq,
	input  logic [R2_WIDTH-1:0]    r2,
	output result_t                res
);

	localparam int XW = 2 * CW + 3;
	localparam int CMPW = (XW > R2_WIDTH + 1) ? XW : R2_WIDTH + 1;

	logic signed [CMPW-1:0] r2_ext, dp_ext, dq_ext;
	logic                   pos_ok, neg_ok, crossing, near;

	always_comb begin
		r2_ext = $signed(CMPW'(r2));
		dp_ext = CMPW'(dp);
		dq_ext = CMPW'(dq);

		pos_ok = (nt >= 0) && (nt <= den) && (nr >= 0) && (nr <= den);
		neg_ok = (nt <= 0) && (nt >= den) && (nr <= 0) && (nr >= den);

		if (den == '0) begin
			crossing = 1'b0;
		end else if (den[XW-1]) begin
			crossing = neg_ok;
		end else begin
			crossing = pos_ok;
		end

		near = (dp_ext < r2_ext) || (dq_ext < r2_ext);

		res.hit      = crossing | near;
		res.crossing = crossing;
		res.near     = near;
	end

endmodule

### rtl/core/stroke_segment_hit_test_top.sv
`timescale 1ns / 1ps

// Stroke segment hit test.
// Input channel: one beat carries an eraser stroke segment (start, end) and one
// drawn line segment (start, end), all signed fixed-point coordinates.
// Output channel: one beat per input beat with hit, hit_by_crossing and
// hit_by_radius, in input order.
// Config: cfg_we writes cfg_wdata into the eraser radius; write only while idle.
// Pipeline: an accepted input beat passes the difference, multiply and combine
// stages and then the output register before it shows as output valid.
// Throughput: one beat per cycle unless stalled; the multiplier is fully pipelined.
// Stall: when out_stall is high with a pending result, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Radius changes reach the comparators through radius_q and then the registered r2_q.
// Reset: arst_n clears all valid bits and sets the radius to 2560 (10.0).
module stroke_segment_hit_test_top import ssht_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [RADIUS_WIDTH-1:0]       cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] stroke_start_x,
	input  logic signed [COORD_WIDTH-1:0] stroke_start_y,
	input  logic signed [COORD_WIDTH-1:0] stroke_end_x,
	input  logic signed [COORD_WIDTH-1:0] stroke_end_y,
	input  logic signed [COORD_WIDTH-1:0] seg_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg_end_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic                          hit_by_crossing,
	output logic                          hit_by_radius
);

	localparam int CW = COORD_WIDTH;

	logic                    en;
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [RADIUS_WIDTH-1:0] radius_q;
	logic [R2_WIDTH-1:0]     r2_q;
	result_t                 res, res_s4;

	logic signed [CW:0]     ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	logic signed [CW:0]     dpx_s1, dpy_s1, dqx_s1, dqy_s1;
	logic signed [2*CW+2:0] den_s3, nt_s3, nr_s3, dp_s3, dq_s3;

	assign en       = !(v_s4 && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			r2_q     <= R2_RESET;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_wdata;
			end
			r2_q <= R2_WIDTH'(radius_q) * R2_WIDTH'(radius_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	ssht_diff #(.CW(CW)) u_diff (
		.clk    (clk),
		.en     (en),
		.sx     (stroke_start_x),
		.sy     (stroke_start_y),
		.ex     (stroke_end_x),
		.ey     (stroke_end_y),
		.px     (seg_start_x),
		.py     (seg_start_y),
		.qx     (seg_end_x),
		.qy     (seg_end_y),
		.ux_s1  (ux_s1),
		.uy_s1  (uy_s1),
		.vx_s1  (vx_s1),
		.vy_s1  (vy_s1),
		.wx_s1  (wx_s1),
		.wy_s1  (wy_s1),
		.dpx_s1 (dpx_s1),
		.dpy_s1 (dpy_s1),
		.dqx_s1 (dqx_s1),
		.dqy_s1 (dqy_s1)
	);

	ssht_mult #(.CW(CW)) u_mult (
		.clk    (clk),
		.en     (en),
		.ux     (ux_s1),
		.uy     (uy_s1),
		.vx     (vx_s1),
		.vy     (vy_s1),
		.wx     (wx_s1),
		.wy     (wy_s1),
		.dpx    (dpx_s1),
		.dpy    (dpy_s1),
		.dqx    (dqx_s1),
		.dqy    (dqy_s1),
		.den_s3 (den_s3),
		.nt_s3  (nt_s3),
		.nr_s3  (nr_s3),
		.dp_s3  (dp_s3),
		.dq_s3  (dq_s3)
	);

	ssht_decide #(.CW(CW)) u_decide (
		.den (den_s3),
		.nt  (nt_s3),
		.nr  (nr_s3),
		.dp  (dp_s3),
		.dq  (dq_s3),
		.r2  (r2_q),
		.res (res)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= res;
		end
	end

	assign out_valid       = v_s4;
	assign hit             = res_s4.hit;
	assign hit_by_crossing = res_s4.crossing;
	assign hit_by_radius   = res_s4.near;

`ifndef SYNTHESIS
	a_hit_is_or: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (hit_by_crossing | hit_by_radius)))
		else $error("hit differs from crossing or radius");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
		else $error("accepted beat did not reach output");

	a_stall_keeps_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> out_valid)
		else $error("result lost during stall");
`endif

endmodule
